@@ rtl/qlz_pkg.sv @@
`default_nettype none
package qlz_pkg;

  localparam int WINDOW_SIZE = 2048;
  localparam int MAX_STRING  = 512;
  localparam int OUT_LANES   = 8;
  localparam int PTR_W       = $clog2(WINDOW_SIZE);

  // Token parser phases
  typedef enum logic [2:0] {
    PH_TOKEN   = 3'd0,
    PH_LITERAL = 3'd1,
    PH_OFFSEL  = 3'd2,
    PH_OFFSET  = 3'd3,
    PH_LEN2    = 3'd4,
    PH_LEN4    = 3'd5
  } phase_t;

  // Step sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_RD,
    S_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;  // capture input beat
    logic take;  // consume one bit
    logic rd;    // read ring for copy
    logic wr;    // write copied byte
    logic fin;   // emit last result
  } cmd_t;

  typedef struct packed {
    logic bit_avail;  // bits left and segment not stopped
    logic str_go;     // current bit completes a string
    logic slot_free;  // output register can take a beat
    logic copy_last;  // one copy byte left
  } status_t;

endpackage
`default_nettype wire

@@ rtl/qlz_ctrl.sv @@
`default_nettype none
module qlz_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire qlz_pkg::status_t st,
  output qlz_pkg::cmd_t        cmd
);
  import qlz_pkg::*;

  state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_BIT;
      S_BIT: begin
        if (!st.bit_avail) begin
          state_next = S_DONE;
        end else if (st.slot_free && st.str_go) begin
          state_next = S_RD;
        end
      end
      S_RD: state_next = S_WR;
      S_WR: begin
        if (st.slot_free) begin
          state_next = st.copy_last ? S_BIT : S_RD;
        end
      end
      S_DONE: if (st.slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_BIT:  cmd.take = st.bit_avail && st.slot_free;
      S_RD:   cmd.rd   = 1'b1;
      S_WR:   cmd.wr   = st.slot_free;
      S_DONE: cmd.fin  = st.slot_free;
      default: ;
    endcase
  end

  a_rd_then_wr: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |=> state == S_WR) else $error("copy read not followed by write");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> state == S_IDLE) else $error("final beat did not end the step");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("more than one command at once");

endmodule
`default_nettype wire

@@ rtl/qlz_datapath.sv @@
`default_nettype none
module qlz_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire qlz_pkg::cmd_t    cmd,
  output qlz_pkg::status_t      st,
  input  wire logic [7:0]       data_byte,
  input  wire logic             segment_start,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [63:0]           out_bytes,
  output logic [3:0]            byte_count,
  output logic                  run_last,
  output logic                  segment_end,
  output logic                  decode_error
);
  import qlz_pkg::*;

  logic [7:0]       ring [WINDOW_SIZE];
  logic [PTR_W-1:0] wp;
  logic             wrapped;
  logic [7:0]       rdata;
  logic             rok;

  logic [7:0]       shreg;
  logic [3:0]       bits_left;
  phase_t           phase, phase_next;
  logic [10:0]      facc, facc_next;
  logic [3:0]       brem, brem_next;
  logic [9:0]       lacc, lacc_next;
  logic [10:0]      ohold, ohold_next;
  logic [1:0]       stopped, stopped_next;
  logic             lit_put, go;
  logic [10:0]      total;
  logic [10:0]      shifted;
  logic [3:0]       brem_dec;
  logic [1:0]       f2;
  logic [3:0]       f4;

  logic [PTR_W-1:0] copy_src;
  logic [9:0]       copy_left;
  logic [63:0]      lane_word;
  logic [3:0]       lane_cnt;

  logic             put_en;
  logic [7:0]       put_b;
  logic             bitv;

  assign bitv     = shreg[7];
  assign shifted  = {facc[9:0], bitv};
  assign brem_dec = brem - 4'd1;
  assign f2       = {facc[0], bitv};
  assign f4       = {facc[2:0], bitv};

  // Decode one bit of the token stream
  always_comb begin
    phase_next   = phase;
    facc_next    = facc;
    brem_next    = brem;
    lacc_next    = lacc;
    ohold_next   = ohold;
    stopped_next = stopped;
    lit_put      = 1'b0;
    go           = 1'b0;
    total        = '0;
    unique case (phase)
      PH_TOKEN: begin
        facc_next = '0;
        if (!bitv) begin
          brem_next  = 4'd8;
          phase_next = PH_LITERAL;
        end else begin
          phase_next = PH_OFFSEL;
        end
      end
      PH_LITERAL: begin
        facc_next = shifted;
        brem_next = brem_dec;
        if (brem_dec == 4'd0) begin
          lit_put    = 1'b1;
          phase_next = PH_TOKEN;
        end
      end
      PH_OFFSEL: begin
        brem_next  = bitv ? 4'd7 : 4'd11;
        facc_next  = '0;
        phase_next = PH_OFFSET;
      end
      PH_OFFSET: begin
        facc_next = shifted;
        brem_next = brem_dec;
        if (brem_dec == 4'd0) begin
          if (shifted == 11'd0) begin
            stopped_next[0] = 1'b1;
            phase_next      = PH_TOKEN;
          end else begin
            ohold_next = shifted;
            lacc_next  = '0;
            facc_next  = '0;
            brem_next  = 4'd2;
            phase_next = PH_LEN2;
          end
        end
      end
      PH_LEN2: begin
        facc_next = {9'd0, f2};
        brem_next = brem_dec;
        total     = {1'b0, lacc} + {9'd0, f2} + 11'd2;
        if (brem_dec == 4'd0) begin
          if (f2 != 2'd3) begin
            phase_next = PH_TOKEN;
            if (total > 11'(MAX_STRING)) begin
              stopped_next[1] = 1'b1;
            end else begin
              go = 1'b1;
            end
          end else begin
            lacc_next = lacc + 10'd3;
            facc_next = '0;
            if (lacc + 10'd3 >= 10'd6) begin
              brem_next  = 4'd4;
              phase_next = PH_LEN4;
            end else begin
              brem_next = 4'd2;
            end
          end
        end
      end
      PH_LEN4: begin
        facc_next = {7'd0, f4};
        brem_next = brem_dec;
        total     = {1'b0, lacc} + {7'd0, f4} + 11'd2;
        if (brem_dec == 4'd0) begin
          if (f4 != 4'd15) begin
            phase_next = PH_TOKEN;
            if (total > 11'(MAX_STRING)) begin
              stopped_next[1] = 1'b1;
            end else begin
              go = 1'b1;
            end
          end else begin
            lacc_next = lacc + 10'd15;
            facc_next = '0;
            brem_next = 4'd4;
            if ({1'b0, lacc + 10'd15} + 11'd2 > 11'(MAX_STRING)) begin
              stopped_next[1] = 1'b1;
              phase_next      = PH_TOKEN;
            end
          end
        end
      end
      default: phase_next = PH_TOKEN;
    endcase
  end

  assign st.bit_avail = (bits_left != 4'd0) && (stopped == 2'b00);
  assign st.str_go    = go;
  assign st.slot_free = !out_valid || !out_stall;
  assign st.copy_last = (copy_left == 10'd1);

  assign put_en = (cmd.take && lit_put) || cmd.wr;
  assign put_b  = cmd.wr ? (rok ? rdata : 8'd0) : shifted[7:0];

  // Ring memory
  always_ff @(posedge clk) begin
    if (put_en) begin
      ring[wp] <= put_b;
    end
    if (cmd.rd) begin
      rdata <= ring[copy_src];
    end
  end

  // Parser, pointers and lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      wrapped   <= 1'b0;
      phase     <= PH_TOKEN;
      facc      <= '0;
      brem      <= '0;
      lacc      <= '0;
      ohold     <= '0;
      stopped   <= '0;
      bits_left <= '0;
      lane_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        shreg     <= data_byte;
        bits_left <= 4'd8;
        lane_word <= '0;
        lane_cnt  <= '0;
        if (segment_start) begin
          phase   <= PH_TOKEN;
          facc    <= '0;
          brem    <= '0;
          lacc    <= '0;
          ohold   <= '0;
          stopped <= '0;
        end
      end
      if (cmd.take) begin
        shreg     <= {shreg[6:0], 1'b0};
        bits_left <= bits_left - 4'd1;
        phase     <= phase_next;
        facc      <= facc_next;
        brem      <= brem_next;
        lacc      <= lacc_next;
        ohold     <= ohold_next;
        stopped   <= stopped_next;
        if (go) begin
          copy_src  <= wp - ohold;
          copy_left <= total[9:0];
        end
      end
      if (cmd.rd) begin
        rok <= wrapped || (copy_src < wp);
      end
      if (cmd.wr) begin
        copy_src  <= copy_src + 1'b1;
        copy_left <= copy_left - 10'd1;
      end
      // Put a byte: flush a full lane word first
      if (put_en) begin
        wp <= wp + 1'b1;
        if (wp == '1) begin
          wrapped <= 1'b1;
        end
        if (lane_cnt == 4'(OUT_LANES)) begin
          out_valid    <= 1'b1;
          out_bytes    <= lane_word;
          byte_count   <= lane_cnt;
          run_last     <= 1'b0;
          segment_end  <= 1'b0;
          decode_error <= 1'b0;
          lane_word    <= {56'd0, put_b};
          lane_cnt     <= 4'd1;
        end else begin
          lane_word[lane_cnt[2:0]*8 +: 8] <= put_b;
          lane_cnt <= lane_cnt + 4'd1;
        end
      end
      if (cmd.fin) begin
        out_valid    <= 1'b1;
        out_bytes    <= lane_word;
        byte_count   <= lane_cnt;
        run_last     <= 1'b1;
        segment_end  <= stopped[0];
        decode_error <= stopped[1];
      end
    end
  end

  a_lane_max: assert property (@(posedge clk) disable iff (rst)
    lane_cnt <= 4'(OUT_LANES)) else $error("lane count overflow");
  a_wr_left: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> copy_left != 10'd0) else $error("copy write with no bytes left");
  a_last_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && run_last |-> $past(cmd.fin)) else $error("stray last beat");

endmodule
`default_nettype wire

@@ rtl/qic122_lz_decompressor_top.sv @@
`default_nettype none
// channel | handshake          | payload
// in      | in_valid/in_stall  | data_byte, segment_start
// out     | out_valid/out_stall| out_bytes, byte_count, run_last, segment_end, decode_error
// One bit of the input beat is decoded per cycle while the output can take a beat and no
// string is being copied; each copied string byte takes a ring read, then a write.
// Once the segment has stopped, the remaining bits are skipped and the beat ends sooner.
// Each beat yields one or more output beats; the last carries run_last.
// Reset clears parser and write pointer; ring entries not yet written read as zero.
// A stalled output holds the decoder until the beat is taken.
module qic122_lz_decompressor_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        segment_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_bytes,
  output logic [3:0]       byte_count,
  output logic             run_last,
  output logic             segment_end,
  output logic             decode_error
);
  import qlz_pkg::*;

  cmd_t    cmd;
  status_t st;

  qlz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  qlz_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .data_byte     (data_byte),
    .segment_start (segment_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bytes     (out_bytes),
    .byte_count    (byte_count),
    .run_last      (run_last),
    .segment_end   (segment_end),
    .decode_error  (decode_error)
  );

endmodule
`default_nettype wire
